### design/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_W      = 48;
    localparam int AMT_W       = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_DELAY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [ID_BITS-1:0] t_id;

    typedef struct packed {
        logic  valid;
        t_time deadline;
        t_id   id;
        logic  cancelled;
    } t_entry;

    typedef enum logic [4:0] {
        OP_HOLD   = 5'b00001,
        OP_INSERT = 5'b00010,
        OP_POP    = 5'b00100,
        OP_CANCEL = 5'b01000,
        OP_MOVE   = 5'b10000
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_time    key;
        t_id      id;
        logic     cancelled;
    } t_cell_cmd;

    typedef struct packed {
        logic match;
        logic cand;
        logic first_cand;
    } t_cell_flags;

endpackage

### design/deadline_timer_queue_unit.sv
// Top level of the deadline timer queue: millisecond clock, cell chain and sequencer.
//
// The block keeps a 48-bit millisecond clock and up to QUEUE_DEPTH pending timers
// in a chain of cells sorted by deadline, the earliest in the first cell. A command
// transfer happens at a clock edge with start high and busy low. Push and cancel
// update the chain, then present the status result. A tick advances the clock,
// then lets expired timers leave through the head cell one at a time, finds the
// head not expired and presents the status result. Each expired timer that was
// not cancelled produces a fired result in the cycle after it leaves. A delay
// relocates the matching timers whose deadline moves, one timer per cycle, until
// it sees that no candidate is left, then presents the status result. Every
// command ends with a status result that carries last. Results appear for exactly
// one cycle, marked by o_valid, and cannot be stalled; a new command may be
// started in the cycle in which the status result is shown.
module deadline_timer_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_amount_ms,
    output logic        o_valid,
    output logic        o_kind,
    output logic [7:0]  o_fired_id,
    output logic [1:0]  o_status,
    output logic        o_earliest_valid,
    output logic [47:0] o_earliest_deadline,
    output logic [4:0]  o_pending_count,
    output logic        o_last
);
    import dtq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_DELAY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_time            r_time, n_time;
    t_time            r_key, n_key;
    t_id              r_id, n_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_status, n_status;

    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind;
    logic [7:0]  r_out_id, n_out_id;
    logic [1:0]  r_out_status, n_out_status;
    logic        r_out_evalid, n_out_evalid;
    t_time       r_out_edead, n_out_edead;
    logic [4:0]  r_out_count, n_out_count;
    logic        r_out_last, n_out_last;

    t_cell_cmd   w_cmd;
    t_entry      w_entry [QUEUE_DEPTH+2];
    logic        w_le    [QUEUE_DEPTH+2];
    logic        w_after [QUEUE_DEPTH+1];
    t_cell_flags w_flags [QUEUE_DEPTH];

    t_id         w_in_id;
    logic [48:0] w_sum;
    t_time       w_sat;
    t_entry      w_head;
    logic        w_expired;
    logic        w_any_match;
    logic        w_any_cand;
    logic        w_move_canc;
    logic        w_full;

    // The chain is padded with an empty slot at each end.
    assign w_entry[0]             = '0;
    assign w_entry[QUEUE_DEPTH+1] = '0;
    assign w_le[0]                = 1'b1;
    assign w_le[QUEUE_DEPTH+1]    = 1'b0;
    assign w_after[0]             = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dtq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_entry  (w_entry[g]),
            .i_right_entry (w_entry[g+2]),
            .i_left_le     (w_le[g]),
            .i_right_le    (w_le[g+2]),
            .i_left_after  (w_after[g]),
            .o_entry       (w_entry[g+1]),
            .o_le          (w_le[g+1]),
            .o_after       (w_after[g+1]),
            .o_flags       (w_flags[g])
        );
    end

    always_comb begin
        w_any_match = 1'b0;
        w_any_cand  = 1'b0;
        w_move_canc = 1'b0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_any_match = w_any_match | w_flags[k].match;
            w_any_cand  = w_any_cand  | w_flags[k].cand;
            w_move_canc = w_move_canc | (w_flags[k].first_cand & w_entry[k+1].cancelled);
        end
    end

    // Saturating deadline: now plus the requested milliseconds, clamped to the top value.
    assign w_in_id   = ID_BITS'(i_timer_id);
    assign w_sum     = {1'b0, r_time} + 49'(i_amount_ms);
    assign w_sat     = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
    assign w_head    = w_entry[1];
    assign w_expired = w_head.valid && (w_head.deadline <= r_time);
    assign w_full    = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_key        = r_key;
        n_id         = r_id;
        n_count      = r_count;
        n_status     = r_status;
        n_out_valid  = 1'b0;
        n_out_kind   = KIND_FIRED;
        n_out_id     = '0;
        n_out_status = ST_OK;
        n_out_evalid = 1'b0;
        n_out_edead  = '0;
        n_out_count  = '0;
        n_out_last   = 1'b0;

        w_cmd.op        = OP_HOLD;
        w_cmd.key       = r_key;
        w_cmd.id        = r_id;
        w_cmd.cancelled = w_move_canc;

        unique case (r_state)
            S_IDLE: begin
                w_cmd.key = w_sat;
                w_cmd.id  = w_in_id;
                if (start) begin
                    unique case (i_mode)
                        MODE_PUSH: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.op = OP_INSERT;
                                n_count  = r_count + 1'b1;
                                n_status = ST_OK;
                            end
                            n_state = S_DONE;
                        end
                        MODE_TICK: begin
                            n_time   = w_sat;
                            n_status = ST_OK;
                            n_state  = S_DRAIN;
                        end
                        MODE_CANCEL: begin
                            w_cmd.op = OP_CANCEL;
                            n_status = w_any_match ? ST_OK : ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                        MODE_DELAY: begin
                            n_key   = w_sat;
                            n_id    = w_in_id;
                            n_state = S_DELAY;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                // Expired timers leave through the head, one per cycle.
                if (w_expired) begin
                    w_cmd.op = OP_POP;
                    n_count  = r_count - 1'b1;
                    if (!w_head.cancelled) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_FIRED;
                        n_out_id    = 8'(w_head.id);
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DELAY: begin
                // Matching ids never change, so the match set is the same every cycle.
                if (w_any_cand) begin
                    w_cmd.op = OP_MOVE;
                end else begin
                    n_status = w_any_match ? ST_OK : ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                n_out_valid  = 1'b1;
                n_out_kind   = KIND_STATUS;
                n_out_status = r_status;
                n_out_evalid = w_head.valid;
                n_out_edead  = w_head.valid ? w_head.deadline : '0;
                n_out_count  = 5'(r_count);
                n_out_last   = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_id         <= n_id;
        r_status     <= n_status;
        r_out_kind   <= n_out_kind;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_evalid <= n_out_evalid;
        r_out_edead  <= n_out_edead;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_kind              = r_out_kind;
    assign o_fired_id          = r_out_id;
    assign o_status            = r_out_status;
    assign o_earliest_valid    = r_out_evalid;
    assign o_earliest_deadline = r_out_edead;
    assign o_pending_count     = r_out_count;
    assign o_last              = r_out_last;

`ifndef SYNTH
    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("timer count exceeds queue depth");

    // The head cell holds a timer exactly when the count is nonzero.
    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_head.valid)
        else $error("head cell and timer count disagree");

    // The closing status result is shown while the block is already free.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy still high with the final result");

    // A pop only happens in the drain state and only on an expired head.
    a_pop_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_POP) |-> (r_state == S_DRAIN && w_expired))
        else $error("head removed without expiry");
`endif

endmodule

### design/dtq_cell.sv
// One slot of the sorted timer chain; it shifts entries to and from its neighbors.
module dtq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtq_pkg::t_cell_cmd  i_cmd,
    input  dtq_pkg::t_entry     i_left_entry,
    input  dtq_pkg::t_entry     i_right_entry,
    input  logic                i_left_le,
    input  logic                i_right_le,
    input  logic                i_left_after,
    output dtq_pkg::t_entry     o_entry,
    output logic                o_le,
    output logic                o_after,
    output dtq_pkg::t_cell_flags o_flags
);
    import dtq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_entry w_new;
    logic   w_le;
    logic   w_match;
    logic   w_cand;
    logic   w_after;

    always_comb begin
        // The entry holds a deadline at or before the key: it stays ahead of a new one.
        w_le    = r_entry.valid && (r_entry.deadline <= i_cmd.key);
        w_match = r_entry.valid && (r_entry.id == i_cmd.id);
        w_cand  = w_match && (r_entry.deadline < i_cmd.key);
        w_after = i_left_after || w_cand;

        w_new.valid     = 1'b1;
        w_new.deadline  = i_cmd.key;
        w_new.id        = i_cmd.id;
        w_new.cancelled = (i_cmd.op == OP_MOVE) ? i_cmd.cancelled : 1'b0;

        n_entry = r_entry;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (!i_left_le) begin
                    n_entry = i_left_entry;
                end else if (!w_le) begin
                    n_entry = w_new;
                end
            end
            OP_POP: begin
                n_entry = i_right_entry;
            end
            OP_CANCEL: begin
                if (w_match) begin
                    n_entry.cancelled = 1'b1;
                end
            end
            OP_MOVE: begin
                // The last slot at or before the new deadline takes the moved timer;
                // slots from the first candidate up to it close the gap.
                if (w_le && !i_right_le) begin
                    n_entry = w_new;
                end else if (w_after && i_right_le) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry            = r_entry;
    assign o_le               = w_le;
    assign o_after            = w_after;
    assign o_flags.match      = w_match;
    assign o_flags.cand       = w_cand;
    assign o_flags.first_cand = w_cand && !i_left_after;

endmodule
